@@ src/kss_pkg.sv @@
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants of the key sorted stack
// Key width, command and status codes, and the control word that is
// broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

  localparam int KeyW     = 16;
  localparam int PortPayW = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } kss_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } kss_status_e;

  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic signed [KeyW-1:0] key;
  } kss_ctrl_t;

endpackage

`default_nettype wire

@@ src/kss_cell.sv @@
// ----------------------------------------------------------------------------
// kss_cell: one slot of the sorted chain
// Holds one entry. Cells are ordered by descending key, so cell 0 holds the
// greatest key. On a push a cell keeps its entry, takes the new entry or
// takes its upper neighbor's entry; on a pop it takes its lower neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_cell
  import kss_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic                   clk_i,
  input  wire kss_ctrl_t              ctrl_i,
  input  wire logic                   occupied_i,
  input  wire logic [W-1:0]           new_payload_i,
  input  wire logic                   prev_gt_i,
  input  wire logic signed [KeyW-1:0] prev_key_i,
  input  wire logic [W-1:0]           prev_payload_i,
  input  wire logic signed [KeyW-1:0] next_key_i,
  input  wire logic [W-1:0]           next_payload_i,
  output logic                        gt_o,
  output logic signed [KeyW-1:0]      key_o,
  output logic [W-1:0]                payload_o
);

  logic signed [KeyW-1:0] key_q, key_d;
  logic [W-1:0]           payload_q, payload_d;

  // Entries with a strictly greater key stay ahead of the new entry.
  assign gt_o = occupied_i && (key_q > ctrl_i.key);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.push && !gt_o) begin
      if (prev_gt_i) begin
        key_d     = ctrl_i.key;
        payload_d = new_payload_i;
      end else begin
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end
    end else if (ctrl_i.pop) begin
      key_d     = next_key_i;
      payload_d = next_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

@@ src/key_sorted_stack.sv @@
// ----------------------------------------------------------------------------
// key_sorted_stack: bounded list of entries sorted by signed key
// Push inserts ahead of all entries of equal or smaller key; pop removes the
// entry of greatest key (newest first among equal keys).
// ----------------------------------------------------------------------------
// The block takes one item per cycle while out_ready_i is high and answers it
// with one result. Every cell of the chain compares its key with the new key at
// the same time and shifts in one step, so neither push nor pop depends on the
// fill level. The result register holds the status; the entry count and the top
// entry are read straight from the count register and the first cell, so a new
// item is taken in the same cycle in which the previous result leaves. A push
// into a full list reports full, a pop from an empty list reports empty, and
// neither changes the list. Top key and payload read 0 when empty.
`default_nettype none

module key_sorted_stack
  import kss_pkg::*;
#(
  parameter int DEPTH         = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             command_i,
  input  wire logic signed [KeyW-1:0]           depth_key_i,
  input  wire logic [PortPayW-1:0]              payload_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            status_o,
  output logic [$clog2(DEPTH+1)-1:0]            entry_count_o,
  output logic signed [KeyW-1:0]                top_key_o,
  output logic [PortPayW-1:0]                   top_payload_o
);

  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int StoreW = (PAYLOAD_WIDTH < PortPayW) ? PAYLOAD_WIDTH : PortPayW;

  logic                   accept;
  logic                   full, empty;
  kss_ctrl_t              ctrl;
  kss_status_e            status_d, status_q;
  logic                   out_valid_q;
  logic [CntW-1:0]        count_q, count_d;

  logic                   gt    [DEPTH];
  logic signed [KeyW-1:0] keys  [DEPTH];
  logic [StoreW-1:0]      pays  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.key  = depth_key_i;
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    count_d   = count_q;
    status_d  = ST_DONE;
    if (accept) begin
      if (kss_cmd_e'(command_i) == CMD_PUSH) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push = 1'b1;
          count_d   = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.pop = 1'b1;
          count_d  = count_q - CntW'(1);
        end
      end
    end
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic                   prev_gt;
    logic signed [KeyW-1:0] prev_key, next_key;
    logic [StoreW-1:0]      prev_pay, next_pay;

    if (j == 0) begin : g_first
      assign prev_gt  = 1'b1;
      assign prev_key = keys[j];
      assign prev_pay = pays[j];
    end else begin : g_mid
      assign prev_gt  = gt[j-1];
      assign prev_key = keys[j-1];
      assign prev_pay = pays[j-1];
    end

    if (j == DEPTH - 1) begin : g_last
      assign next_key = keys[j];
      assign next_pay = pays[j];
    end else begin : g_inner
      assign next_key = keys[j+1];
      assign next_pay = pays[j+1];
    end

    kss_cell #(
      .W(StoreW)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (CntW'(j) < count_q),
      .new_payload_i  (payload_i[StoreW-1:0]),
      .prev_gt_i      (prev_gt),
      .prev_key_i     (prev_key),
      .prev_payload_i (prev_pay),
      .next_key_i     (next_key),
      .next_payload_i (next_pay),
      .gt_o           (gt[j]),
      .key_o          (keys[j]),
      .payload_o      (pays[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign top_key_o     = empty ? '0 : keys[0];
  assign top_payload_o = empty ? '0 : PortPayW'(pays[0]);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> empty)
    else $error("empty status with entries stored");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the list");

  a_top_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> keys[0] >= keys[1])
    else $error("top entry is not the greatest key");

endmodule

`default_nettype wire
